>>> rtl/ax25ahp_pkg.sv
`default_nettype none

package ax25ahp_pkg;

  // One input transaction: a raw frame byte plus the end-of-frame flag.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  addr_role;
    logic [2:0]  repeater_index;
    logic [41:0] callsign;
    logic [2:0]  callsign_length;
    logic [3:0]  ssid;
    logic        repeated;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [8:0]  payload_length;
    logic        last;
  } out_item_t;

  // Results produced by one accepted byte, packed in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  typedef enum logic [2:0] {
    KIND_ADDR    = 3'd0,
    KIND_CTRL    = 3'd1,
    KIND_PID     = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ROLE_DEST     = 2'd0,
    ROLE_SOURCE   = 2'd1,
    ROLE_REPEATER = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_SOURCE = 3'd2,
    ST_NO_CTRL   = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_UNTERM    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_ADDR    = 2'd0,
    PH_CTRL    = 2'd1,
    PH_PID     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  localparam logic [6:0] CHAR_SPACE  = 7'h20;
  localparam logic [6:0] CHAR_A      = 7'h41;
  localparam logic [6:0] CHAR_Z      = 7'h5A;
  localparam logic [6:0] CHAR_0      = 7'h30;
  localparam logic [6:0] CHAR_9      = 7'h39;
  localparam logic [3:0] MIN_FRAME   = 4'd14;
  localparam logic [3:0] COUNT_SAT   = 4'd15;
  localparam logic [2:0] SSID_OCTET  = 3'd6;

endpackage

`default_nettype wire

>>> rtl/ax25ahp_parser.sv
`default_nettype none

module ax25ahp_parser #(
  parameter int MAX_REPEATERS = 8,
  parameter int MAX_PAYLOAD   = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire ax25ahp_pkg::in_item_t  item,
  output ax25ahp_pkg::push_t      push
);
  import ax25ahp_pkg::*;

  localparam int ACW = $clog2(MAX_REPEATERS + 3);
  localparam int PCW = $clog2(MAX_PAYLOAD + 1);

  logic [3:0]     fbc_r,  fbc_nxt;
  phase_t         phase_r, phase_nxt;
  logic [2:0]     abi_r,  abi_nxt;
  logic [ACW-1:0] acnt_r, acnt_nxt;
  logic [41:0]    call_r, call_nxt;
  logic           bad_r,  bad_nxt;
  status_t        err_r,  err_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;

  logic [7:0] b;
  logic [6:0] c;
  logic       char_ok;
  logic       main_vld;
  out_item_t  main_item;
  out_item_t  stat_item;
  status_t    st;

  function automatic logic [2:0] trim_len(logic [41:0] call);
    logic [2:0] len;
    logic       stop;
    len  = 3'd6;
    stop = 1'b0;
    // char 0 here is the last character of the callsign
    for (int i = 0; i < 6; i++) begin
      if (!stop && call[7*i +: 7] == CHAR_SPACE) begin
        len = len - 3'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return len;
  endfunction

  assign b = item.byte_value;
  assign c = b[7:1];
  assign char_ok = !b[0] && (c == CHAR_SPACE || (c >= CHAR_A && c <= CHAR_Z) ||
                             (c >= CHAR_0 && c <= CHAR_9));

  always_comb begin
    fbc_nxt   = fbc_r;
    phase_nxt = phase_r;
    abi_nxt   = abi_r;
    acnt_nxt  = acnt_r;
    call_nxt  = call_r;
    bad_nxt   = bad_r;
    err_nxt   = err_r;
    pcnt_nxt  = pcnt_r;
    main_vld  = 1'b0;
    main_item = '0;
    stat_item = '0;
    st        = ST_OK;
    push      = '0;

    if (take) begin
      if (fbc_r != COUNT_SAT) begin
        fbc_nxt = fbc_r + 4'd1;
      end

      if (err_r == ST_OK) begin
        unique case (phase_r)
          PH_ADDR: begin
            if (abi_r != SSID_OCTET) begin
              if (!char_ok) begin
                bad_nxt = 1'b1;
              end
              call_nxt = {call_r[34:0], c};
              abi_nxt  = abi_r + 3'd1;
            end else if (bad_r) begin
              err_nxt = ST_BAD_ADDR;
            end else begin
              main_vld                  = 1'b1;
              main_item.result_kind     = KIND_ADDR;
              if (acnt_r == ACW'(0)) begin
                main_item.addr_role = ROLE_DEST;
              end else if (acnt_r == ACW'(1)) begin
                main_item.addr_role = ROLE_SOURCE;
              end else begin
                main_item.addr_role      = ROLE_REPEATER;
                main_item.repeater_index = 3'(acnt_r - ACW'(2));
              end
              main_item.callsign        = call_r;
              main_item.callsign_length = trim_len(call_r);
              main_item.ssid            = b[4:1];
              main_item.repeated        = b[7];
              acnt_nxt = acnt_r + ACW'(1);
              abi_nxt  = '0;
              call_nxt = '0;
              bad_nxt  = 1'b0;
              if (b[0]) begin
                if (acnt_r == ACW'(0)) begin
                  err_nxt = ST_NO_SOURCE;
                end else begin
                  phase_nxt = PH_CTRL;
                end
              end else if (acnt_nxt >= ACW'(MAX_REPEATERS + 2)) begin
                err_nxt = ST_UNTERM;
              end
            end
          end
          PH_CTRL: begin
            main_vld              = 1'b1;
            main_item.result_kind = KIND_CTRL;
            main_item.data_byte   = b;
            phase_nxt             = PH_PID;
          end
          PH_PID: begin
            main_vld              = 1'b1;
            main_item.result_kind = KIND_PID;
            main_item.data_byte   = b;
            phase_nxt             = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (pcnt_r < PCW'(MAX_PAYLOAD)) begin
              main_vld              = 1'b1;
              main_item.result_kind = KIND_PAYLOAD;
              main_item.data_byte   = b;
              pcnt_nxt              = pcnt_r + PCW'(1);
            end
          end
          default: ;
        endcase
      end

      if (item.frame_end) begin
        if (fbc_nxt < MIN_FRAME)        st = ST_SHORT;
        else if (err_nxt != ST_OK)      st = err_nxt;
        else if (phase_nxt == PH_ADDR)  st = ST_UNTERM;
        else if (phase_nxt != PH_PAYLOAD) st = ST_NO_CTRL;
        else                            st = ST_OK;
        stat_item.result_kind = KIND_STATUS;
        stat_item.status      = st;
        stat_item.payload_length = (st == ST_OK) ? 9'(pcnt_nxt) : 9'd0;
        stat_item.last        = 1'b1;
        fbc_nxt   = '0;
        phase_nxt = PH_ADDR;
        abi_nxt   = '0;
        acnt_nxt  = '0;
        call_nxt  = '0;
        bad_nxt   = 1'b0;
        err_nxt   = ST_OK;
        pcnt_nxt  = '0;
      end

      if (main_vld) begin
        push.item0 = main_item;
        push.item1 = stat_item;
        push.cnt   = item.frame_end ? 2'd2 : 2'd1;
      end else begin
        push.item0 = stat_item;
        push.cnt   = item.frame_end ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbc_r   <= '0;
      phase_r <= PH_ADDR;
      abi_r   <= '0;
      acnt_r  <= '0;
      call_r  <= '0;
      bad_r   <= 1'b0;
      err_r   <= ST_OK;
      pcnt_r  <= '0;
    end else begin
      fbc_r   <= fbc_nxt;
      phase_r <= phase_nxt;
      abi_r   <= abi_nxt;
      acnt_r  <= acnt_nxt;
      call_r  <= call_nxt;
      bad_r   <= bad_nxt;
      err_r   <= err_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ax25ahp_outq.sv
`default_nettype none

module ax25ahp_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ax25ahp_pkg::push_t   push,
  input  wire logic                 pop,
  output ax25ahp_pkg::out_item_t    head,
  output logic [2:0]                level,
  output logic                      room2
);
  import ax25ahp_pkg::*;

  out_item_t  mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] lvl_r, lvl_nxt;

  assign head  = mem_r[rp_r];
  assign level = lvl_r;
  assign room2 = (lvl_r < 3'd3);

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    lvl_nxt = lvl_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      lvl_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ax25_address_header_parser.sv
`default_nettype none

// Channel  | Ports                          | Transaction
// ---------+--------------------------------+-----------------------------------
// input    | in_valid, in_ready, in_item    | one frame byte + frame_end flag
// result   | out_valid, out_ready, out_item | address, control, PID, payload
//          |                                | byte or closing frame status
//
// Each byte is decoded in the cycle it is accepted; its results (zero, one or
// two) land in a 4-entry result queue and are visible on the next cycle.
// One byte per cycle is accepted while the queue holds two or fewer results,
// so the sustained rate is one byte per cycle, bounded by the single output
// port when a frame-end byte also emits a data result (two results).
// rst_n (sync, active low) clears parser state and empties the queue.
// out_ready low stalls the input once three results are waiting in the queue.

module ax25_address_header_parser #(
  parameter int MAX_REPEATERS = 8,
  parameter int MAX_PAYLOAD   = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ax25ahp_pkg::in_item_t  in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ax25ahp_pkg::out_item_t      out_item
);
  import ax25ahp_pkg::*;

  logic       take;
  logic       pop;
  logic       room2;
  logic [2:0] q_level;
  push_t      push;

  // accept a byte only when the queue has space for its worst-case two results
  assign in_ready  = room2;
  assign take      = in_valid && in_ready;
  assign out_valid = (q_level != 3'd0);
  assign pop       = out_valid && out_ready;

  ax25ahp_parser #(
    .MAX_REPEATERS (MAX_REPEATERS),
    .MAX_PAYLOAD   (MAX_PAYLOAD)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_item),
    .push  (push)
  );

  ax25ahp_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (out_item),
    .level (q_level),
    .room2 (room2)
  );

`ifndef ASSERT_OFF
  // queue never exceeds its four entries
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= 3'd4)
    else $error("result queue overflow");

  // nothing is queued without an accepted byte
  a_push_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> push.cnt == 2'd0)
    else $error("result pushed without input transaction");

  // a frame-end byte always yields a closing status as its final result
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_item.frame_end) |->
      ((push.cnt == 2'd1 && push.item0.last) || (push.cnt == 2'd2 && push.item1.last)))
    else $error("frame end without closing status");

  // status results appear only on frame-end bytes
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !in_item.frame_end && push.cnt != 2'd0) |->
      (push.cnt == 2'd1 && !push.item0.last))
    else $error("status emitted mid-frame");
`endif

endmodule

`default_nettype wire
